[src/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the Chebyshev interpolator; empty when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CSI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define CSI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define CSI_ASSERT_IMP(lbl, ante, cons)
`define CSI_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[src/csi_pkg.sv]
// ---------------------------------------------------------------------------
// csi_pkg
// Shared constants and fixed-point helpers for the Chebyshev interpolator.
// ---------------------------------------------------------------------------
package csi_pkg;

  localparam int MAX_COEFFS_DEF  = 18;
  localparam int STORE_DEPTH_DEF = 512;

  // configuration register indexes
  localparam logic [2:0] REG_COEFFS     = 3'd0;
  localparam logic [2:0] REG_COMPONENTS = 3'd1;
  localparam logic [2:0] REG_SUBINT     = 3'd2;
  localparam logic [2:0] REG_VEL_EN     = 3'd3;
  localparam logic [2:0] REG_INT_LEN    = 3'd4;

  localparam logic [4:0]  RST_COEFFS     = 5'd14;
  localparam logic [1:0]  RST_COMPONENTS = 2'd3;
  localparam logic [3:0]  RST_SUBINT     = 4'd4;
  localparam logic        RST_VEL_EN     = 1'b1;
  localparam logic [31:0] RST_INT_LEN    = 32'd32;

  localparam logic signed [39:0] ONE_Q30 = 40'sd1073741824;
  localparam logic signed [63:0] P40_MAX = 64'sd549755813887;
  localparam logic signed [63:0] P40_MIN = -64'sd549755813888;
  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  function automatic logic [63:0] mag64(input logic signed [63:0] x);
    return x[63] ? 64'(-x) : 64'(x);
  endfunction

  // magnitude plus sign to saturated signed word
  function automatic logic signed [63:0] sat_mag(input logic [63:0] m, input logic neg);
    if (m[63]) return neg ? S64_MIN : S64_MAX;
    return neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [63:0] x);
    if (x > P40_MAX) return P40_MAX[39:0];
    if (x < P40_MIN) return P40_MIN[39:0];
    return x[39:0];
  endfunction

  function automatic logic signed [63:0] sx40(input logic signed [39:0] x);
    return {{24{x[39]}}, x};
  endfunction

endpackage

[src/csi_mul.sv]
// ---------------------------------------------------------------------------
// csi_mul
// Shared 64x64 signed multiplier, Q30 rounding half away from zero, saturated.
// Four 32x32 partial products, one per cycle, accumulated, then rounded and saturated.
// ---------------------------------------------------------------------------
module csi_mul import csi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic               done,
  output logic signed [63:0] result
);

  localparam logic [2:0] STEP_LAST_PP = 3'd3;
  localparam logic [2:0] STEP_ROUND   = 3'd5;

  logic         run;
  logic [2:0]   step;
  logic [63:0]  ma, mb;
  logic         neg;
  logic [63:0]  pp;
  logic [127:0] acc;
  logic [31:0]  opa, opb;
  logic [1:0]   pidx;
  logic [127:0] acc_add, rsum;
  logic [63:0]  m;

  always_comb begin
    opa  = step[1] ? ma[63:32] : ma[31:0];
    opb  = step[0] ? mb[63:32] : mb[31:0];
    pidx = 2'(step - 3'd1);
    if (pidx == 2'd3)      acc_add = {pp, 64'd0};
    else if (pidx == 2'd0) acc_add = {64'd0, pp};
    else                   acc_add = {32'd0, pp, 32'd0};
    rsum = acc + (128'd1 << 29);
    m    = (|rsum[127:93]) ? '1 : rsum[93:30];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        step <= '0;
      end else if (run) begin
        step <= step + 3'd1;
        if (step == STEP_ROUND) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma  <= mag64(a);
      mb  <= mag64(b);
      neg <= a[63] ^ b[63];
      acc <= '0;
    end else if (run) begin
      if (step <= STEP_LAST_PP) pp <= 64'(opa) * 64'(opb);
      if (step != 3'd0 && step < STEP_ROUND) acc <= acc + acc_add;
      if (step == STEP_ROUND) result <= sat_mag(m, neg);
    end
  end

endmodule

[src/csi_div.sv]
// ---------------------------------------------------------------------------
// csi_div
// Velocity scaling: round(|sum|*k/len) half up, signed and saturated.
// Restoring division, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module csi_div import csi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] sum,
  input  logic [4:0]         k,
  input  logic [31:0]        len,
  output logic               done,
  output logic signed [63:0] result
);

  localparam logic [6:0] DIV_STEPS = 7'd70;

  logic        run;
  logic [6:0]  cnt;
  logic [69:0] num;
  logic [32:0] rem, den;
  logic        neg;
  logic [33:0] rsh;
  logic        ge;
  logic [63:0] m;

  always_comb begin
    rsh = {rem, num[69]};
    ge  = rsh >= {1'b0, den};
    m   = (|num[69:64]) ? '1 : num[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= DIV_STEPS;
      end else if (run) begin
        if (cnt != 7'd0) cnt <= cnt - 7'd1;
        else begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // numerator 2*u*k + len over 2*len gives the half-up rounded quotient
  always_ff @(posedge clk) begin
    if (start) begin
      num <= 70'({mag64(sum), 1'b0}) * 70'(k) + 70'(len);
      den <= {len, 1'b0};
      rem <= '0;
      neg <= sum[63];
    end else if (run) begin
      if (cnt != 7'd0) begin
        rem <= ge ? 33'(rsh - {1'b0, den}) : rsh[32:0];
        num <= {num[68:0], ge};
      end else begin
        result <= sat_mag(m, neg);
      end
    end
  end

endmodule

[src/chebyshev_series_interpolator.sv]
// ---------------------------------------------------------------------------
// chebyshev_series_interpolator
// Chebyshev series evaluation with derivative over a coefficient store.
//
//   channel  direction  handshake            payload
//   input    in         start / busy         mode, coef_index, coef_value,
//                                            time_fraction
//   result   out        valid (one cycle)    component, position, velocity, last
//   config   in         cfg_write            cfg_index, cfg_data
//
// A load writes the store and busy stays low. An evaluation keeps busy high while
// the shared multiplier runs the recurrence steps and the coefficient products,
// and, with velocity on, the velocity products and then the bit-serial divider.
// Results come one word per component, each valid for one cycle; the receiver
// cannot stall. rst is synchronous.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module chebyshev_series_interpolator import csi_pkg::*; #(
  parameter int MAX_COEFFS  = MAX_COEFFS_DEF,
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               mode,
  input  logic [8:0]         coef_index,
  input  logic signed [63:0] coef_value,
  input  logic [32:0]        time_fraction,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               valid,
  output logic [1:0]         component,
  output logic signed [63:0] position,
  output logic signed [63:0] velocity,
  output logic               last
);

  localparam int CW = $clog2(MAX_COEFFS + 1);
  localparam int JW = $clog2(MAX_COEFFS);
  localparam int AW = $clog2(STORE_DEPTH);

  typedef enum logic [13:0] {
    S_IDLE  = 14'h0001,
    S_TREC  = 14'h0002,
    S_TWAIT = 14'h0004,
    S_DREC  = 14'h0008,
    S_DWAIT = 14'h0010,
    S_ADDR  = 14'h0020,
    S_RD    = 14'h0040,
    S_MP    = 14'h0080,
    S_MPW   = 14'h0100,
    S_MV    = 14'h0200,
    S_MVW   = 14'h0400,
    S_DIVS  = 14'h0800,
    S_DIVW  = 14'h1000,
    S_EMIT  = 14'h2000
  } state_t;

  state_t state;

  logic [4:0]  ncf_reg;
  logic [1:0]  ncm_reg;
  logic [3:0]  na_reg;
  logic        ven_reg;
  logic [31:0] len_reg;

  logic [CW-1:0]      ncf, j;
  logic [1:0]         ncm, comp;
  logic [3:0]         na;
  logic [31:0]        len;
  logic               ven;
  logic signed [39:0] twot, tp1, tp2, dp1, dp2;
  logic signed [39:0] tpoly [MAX_COEFFS];
  logic signed [39:0] dpoly [MAX_COEFFS];
  logic [4:0]         cnt;
  logic [AW-1:0]      ptr, rptr;
  logic signed [63:0] pos, vel, vres;

  logic [63:0] mem [STORE_DEPTH];
  logic [63:0] mem_rdata;
  logic        mem_we;
  logic [9:0]  wa;

  // evaluation setup
  logic [CW-1:0]      ncf_c;
  logic [1:0]         ncm_c;
  logic [3:0]         na_c;
  logic [31:0]        len_c;
  logic [32:0]        t_c;
  logic [36:0]        prod;
  logic [4:0]         l_raw;
  logic               at_end;
  logic [2:0]         l_c;
  logic signed [39:0] tc_c;

  logic [JW-1:0]      t_idx;
  logic signed [39:0] t_rd, d_rd;
  logic signed [39:0] tn, dn;
  logic [AW:0]        psum;
  logic [AW-1:0]      ptr_add, rptr_dec;
  logic               last_c;

  logic               mul_start, mul_done;
  logic signed [63:0] mul_a, mul_b, mul_res;
  logic               div_done;
  logic signed [63:0] div_res;
  logic               mul_wait;

  assign busy   = (state != S_IDLE);
  assign mem_we = start && !busy && !mode;
  assign mul_wait = (state == S_TWAIT) || (state == S_DWAIT) || (state == S_MPW) ||
                    (state == S_MVW);

  always_comb begin
    ncf_c = (ncf_reg < 5'd2) ? CW'(2) :
            ((int'(ncf_reg) > MAX_COEFFS) ? CW'(MAX_COEFFS) : CW'(ncf_reg));
    ncm_c = (ncm_reg < 2'd2) ? 2'd2 : ncm_reg;
    na_c  = (na_reg == 4'd0) ? 4'd1 : ((na_reg > 4'd8) ? 4'd8 : na_reg);
    len_c = (len_reg == 32'd0) ? 32'd1 : len_reg;
    t_c   = (time_fraction > 33'h100000000) ? 33'h100000000 : time_fraction;
    prod  = 37'(na_c) * 37'(t_c);
    l_raw = prod[36:32];
    at_end = l_raw >= 5'(na_c);
    l_c   = at_end ? 3'(na_c - 4'd1) : l_raw[2:0];
    tc_c  = at_end ? ONE_Q30 : ($signed({9'd0, prod[31:1]}) - ONE_Q30);
  end

  // store address modulo depth, by repeated subtraction
  always_comb begin
    wa = {1'b0, coef_index};
    for (int s = 0; s < 8; s++) begin
      if (int'(wa) >= STORE_DEPTH) wa = wa - 10'(STORE_DEPTH);
    end
  end

  always_comb begin
    t_idx    = (state == S_DWAIT) ? JW'(j - CW'(1)) : JW'(j);
    t_rd     = tpoly[t_idx];
    d_rd     = dpoly[JW'(j)];
    tn       = sat40(mul_res - sx40(tp2));
    dn       = sat40(mul_res + (sx40(t_rd) <<< 1) - sx40(dp2));
    psum     = (AW+1)'(ptr) + (AW+1)'(ncf);
    ptr_add  = (int'(psum) >= STORE_DEPTH) ? AW'(psum - (AW+1)'(STORE_DEPTH)) : AW'(psum);
    rptr_dec = (rptr == '0) ? AW'(STORE_DEPTH - 1) : rptr - AW'(1);
    last_c   = (comp == ncm - 2'd1);
  end

  always_comb begin
    mul_start = 1'b0;
    mul_a     = sx40(twot);
    mul_b     = sx40(tp1);
    unique case (state)
      S_TREC: mul_start = (j < ncf);
      S_DREC: begin
        mul_start = (j < ncf);
        mul_b     = sx40(dp1);
      end
      S_MP: begin
        mul_start = 1'b1;
        mul_a     = sx40(t_rd);
        mul_b     = $signed(mem_rdata);
      end
      S_MV: begin
        mul_start = 1'b1;
        mul_a     = sx40(d_rd);
        mul_b     = $signed(mem_rdata);
      end
      default: mul_start = 1'b0;
    endcase
  end

  csi_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .done   (mul_done),
    .result (mul_res)
  );

  csi_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (state == S_DIVS),
    .sum    (vel),
    .k      ({na, 1'b0}),
    .len    (len),
    .done   (div_done),
    .result (div_res)
  );

  always_ff @(posedge clk) begin
    if (mem_we) mem[AW'(wa)] <= coef_value;
    mem_rdata <= mem[rptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ncf_reg <= RST_COEFFS;
      ncm_reg <= RST_COMPONENTS;
      na_reg  <= RST_SUBINT;
      ven_reg <= RST_VEL_EN;
      len_reg <= RST_INT_LEN;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_COEFFS:     ncf_reg <= cfg_data[4:0];
        REG_COMPONENTS: ncm_reg <= cfg_data[1:0];
        REG_SUBINT:     na_reg  <= cfg_data[3:0];
        REG_VEL_EN:     ven_reg <= cfg_data[0];
        REG_INT_LEN:    len_reg <= cfg_data;
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= 1'b0;
    end else begin
      valid <= 1'b0;
      unique case (state)
        S_IDLE: if (start && mode) begin
          ncf      <= ncf_c;
          ncm      <= ncm_c;
          na       <= na_c;
          len      <= len_c;
          ven      <= ven_reg;
          cnt      <= 5'(l_c) * 5'(ncm_c);
          twot     <= tc_c <<< 1;
          tpoly[0] <= ONE_Q30;
          tpoly[1] <= tc_c;
          dpoly[0] <= '0;
          dpoly[1] <= ONE_Q30;
          dpoly[2] <= tc_c <<< 2;
          tp1      <= tc_c;
          tp2      <= ONE_Q30;
          j        <= CW'(2);
          state    <= S_TREC;
        end
        S_TREC: begin
          if (j >= ncf) begin
            j     <= CW'(3);
            dp1   <= dpoly[2];
            dp2   <= ONE_Q30;
            state <= S_DREC;
          end else begin
            state <= S_TWAIT;
          end
        end
        S_TWAIT: if (mul_done) begin
          tpoly[JW'(j)] <= tn;
          tp2   <= tp1;
          tp1   <= tn;
          j     <= j + CW'(1);
          state <= S_TREC;
        end
        S_DREC: begin
          if (j >= ncf) begin
            ptr   <= AW'(ncf - CW'(1));
            state <= S_ADDR;
          end else begin
            state <= S_DWAIT;
          end
        end
        S_DWAIT: if (mul_done) begin
          dpoly[JW'(j)] <= dn;
          dp2   <= dp1;
          dp1   <= dn;
          j     <= j + CW'(1);
          state <= S_DREC;
        end
        // walk the top pointer to the chosen subinterval's first component
        S_ADDR: begin
          if (cnt == 5'd0) begin
            comp  <= '0;
            j     <= ncf - CW'(1);
            rptr  <= ptr;
            pos   <= '0;
            vel   <= '0;
            state <= S_RD;
          end else begin
            ptr <= ptr_add;
            cnt <= cnt - 5'd1;
          end
        end
        S_RD: state <= S_MP;
        S_MP: state <= S_MPW;
        S_MPW: if (mul_done) begin
          pos <= sat_add64(pos, mul_res);
          if (j != '0 && ven) begin
            state <= S_MV;
          end else if (j == '0) begin
            state <= ven ? S_DIVS : S_EMIT;
          end else begin
            j     <= j - CW'(1);
            rptr  <= rptr_dec;
            state <= S_RD;
          end
        end
        S_MV: state <= S_MVW;
        S_MVW: if (mul_done) begin
          vel   <= sat_add64(vel, mul_res);
          j     <= j - CW'(1);
          rptr  <= rptr_dec;
          state <= S_RD;
        end
        S_DIVS: state <= S_DIVW;
        S_DIVW: if (div_done) begin
          vres  <= div_res;
          state <= S_EMIT;
        end
        S_EMIT: begin
          valid     <= 1'b1;
          component <= comp;
          position  <= pos;
          velocity  <= ven ? vres : '0;
          last      <= last_c;
          if (last_c) begin
            state <= S_IDLE;
          end else begin
            comp  <= comp + 2'd1;
            ptr   <= ptr_add;
            rptr  <= ptr_add;
            j     <= ncf - CW'(1);
            pos   <= '0;
            vel   <= '0;
            state <= S_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CSI_ASSERT_NXT(a_eval_goes_busy, start && !busy && mode, busy)
  `CSI_ASSERT_IMP(a_valid_mid_busy, valid && !last, busy)
  `CSI_ASSERT_IMP(a_mul_done_awaited, mul_done, mul_wait)
  `CSI_ASSERT_IMP(a_div_done_awaited, div_done, state == S_DIVW)

endmodule
